FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared command and status types for the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_STEP,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_MUL_DONE,
    OP_NEXT_BIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_sq;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_le1;
    logic exp_bit;
    logic last_step;
    logic last_bit;
  } dp_sts_t;

endpackage

FILE: rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Base reduction by shift-subtract, shift-add modular multiplier, registers.
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] modulus,
  input  logic [DATA_WIDTH-1:0] in_base,
  input  logic [DATA_WIDTH-1:0] in_exponent,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] b_r, b_nxt, e_r, e_nxt, r_r, r_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt, mb_r, mb_nxt, ma_r, ma_nxt;
  logic [DATA_WIDTH-1:0] src_r, src_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, bit_r, bit_nxt;

  logic [DATA_WIDTH:0]   dbl, dbl2, sum, sum2, red;
  logic [DATA_WIDTH-1:0] acc_d;

  always_comb begin
    // Doubling then conditional add, each reduced by one compare/subtract.
    dbl   = {acc_r, 1'b0};
    dbl2  = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    acc_d = dbl2[DATA_WIDTH-1:0];
    sum   = {1'b0, acc_d} + {1'b0, ma_r};
    sum2  = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    red   = {acc_r, src_r[DATA_WIDTH-1]};
    red   = (red >= {1'b0, modulus}) ? red - {1'b0, modulus} : red;
  end

  always_comb begin
    b_nxt = b_r; e_nxt = e_r; r_nxt = r_r; acc_nxt = acc_r;
    mb_nxt = mb_r; ma_nxt = ma_r; src_nxt = src_r; cnt_nxt = cnt_r; bit_nxt = bit_r;
    unique case (cmd.op)
      OP_LOAD: begin
        e_nxt = in_exponent; src_nxt = in_base; acc_nxt = '0;
        r_nxt = DATA_WIDTH'(1); cnt_nxt = CW'(DATA_WIDTH - 1); bit_nxt = '0;
      end
      OP_RED_STEP: begin
        acc_nxt = red[DATA_WIDTH-1:0];
        src_nxt = {src_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) b_nxt = red[DATA_WIDTH-1:0];
      end
      OP_MUL_START: begin
        acc_nxt = '0; cnt_nxt = CW'(DATA_WIDTH - 1); ma_nxt = b_r;
        mb_nxt = cmd.sel_sq ? b_r : r_r;
      end
      OP_MUL_STEP: begin
        acc_nxt = mb_r[DATA_WIDTH-1] ? sum2[DATA_WIDTH-1:0] : acc_d;
        mb_nxt  = {mb_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_MUL_DONE: begin
        if (cmd.sel_sq) b_nxt = acc_r;
        else r_nxt = acc_r;
      end
      OP_NEXT_BIT: begin
        e_nxt = e_r >> 1; bit_nxt = bit_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt; e_r <= e_nxt; r_r <= r_nxt; acc_r <= acc_nxt;
    mb_r <= mb_nxt; ma_r <= ma_nxt; src_r <= src_nxt;
    cnt_r <= cnt_nxt; bit_r <= bit_nxt;
  end

  assign sts.mod_le1   = (modulus[DATA_WIDTH-1:1] == '0);
  assign sts.exp_bit   = e_r[0];
  assign sts.last_step = (cnt_r == '0);
  assign sts.last_bit  = (bit_r == CW'(DATA_WIDTH - 1));
  assign result        = r_r;

endmodule

FILE: rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, conditional multiply and square for every exponent bit.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_cmd_t cmd,
  output logic    done,
  output logic    zero
);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MSTART, S_MSTEP, S_MDONE, S_NEXT} state_t;

  state_t state_r, state_nxt;
  logic   sq_r, sq_nxt, done_r, done_nxt, zero_r, zero_nxt;

  always_comb begin
    state_nxt = state_r; sq_nxt = sq_r; done_nxt = 1'b0; zero_nxt = 1'b0;
    cmd = '{op: OP_NONE, sel_sq: sq_r};
    unique case (state_r)
      S_IDLE: begin
        if (start && !done_r) begin
          if (sts.mod_le1) begin
            done_nxt = 1'b1; zero_nxt = 1'b1;
          end else begin
            cmd.op = OP_LOAD; state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        cmd.op = OP_RED_STEP;
        if (sts.last_step) begin
          state_nxt = S_MSTART; sq_nxt = 1'b0;
        end
      end
      S_MSTART: begin
        if (!sq_r && !sts.exp_bit) begin
          sq_nxt = 1'b1;
        end else begin
          cmd.op = OP_MUL_START; state_nxt = S_MSTEP;
        end
      end
      S_MSTEP: begin
        cmd.op = OP_MUL_STEP;
        if (sts.last_step) state_nxt = S_MDONE;
      end
      S_MDONE: begin
        cmd.op = OP_MUL_DONE;
        if (sq_r) state_nxt = S_NEXT;
        else begin
          sq_nxt = 1'b1; state_nxt = S_MSTART;
        end
      end
      S_NEXT: begin
        cmd.op = OP_NEXT_BIT; sq_nxt = 1'b0;
        if (sts.last_bit) begin
          state_nxt = S_IDLE; done_nxt = 1'b1;
        end else state_nxt = S_MSTART;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sq_r <= 1'b0; done_r <= 1'b0; zero_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sq_r <= sq_nxt; done_r <= done_nxt; zero_r <= zero_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;
  assign zero = zero_r;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == S_IDLE) else $error("done outside idle");
  a_zero_done: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r |-> done_r) else $error("zero without done");
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("double done");
`endif

endmodule

FILE: rtl/modular_exponentiation_64_top.sv
// The base reduction and the modular multiplier are both bit-serial (one bit per cycle).
// A modulus of one or zero returns at the next edge. One word at a time: the next word
// is taken in the cycle after each result; results never stall.
// Synchronous active-low reset idles the controller and loads the modulus reset value.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Configuration register, controller and datapath.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_top import mexp_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_base,
  input  logic [DATA_WIDTH-1:0] in_exponent,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_power_mod,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam logic [63:0] ModReset = 64'd3930574699;

  logic [DATA_WIDTH-1:0] mod_r, result;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= ModReset[DATA_WIDTH-1:0];
    else if (cfg_valid) mod_r <= cfg_data;
  end

  mexp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
    .busy(busy), .cmd(cmd), .done(out_valid), .zero(zero)
  );

  mexp_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .modulus(mod_r), .in_base(in_base), .in_exponent(in_exponent),
    .cmd(cmd), .sts(sts), .result(result)
  );

  assign out_power_mod = zero ? '0 : result;

endmodule
